// ===== rtl/adtiu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the angular density unit.
package adtiu_pkg;

  localparam int NCOEF = 11;

  typedef logic signed [33:0] ang_t;
  typedef logic signed [23:0] coef_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam int IX_J1S = 0;
  localparam int IX_J1C = 1;
  localparam int IX_J2S = 2;
  localparam int IX_J2C = 3;
  localparam int IX_J3  = 4;
  localparam int IX_J4  = 5;
  localparam int IX_J5  = 6;
  localparam int IX_J6  = 7;
  localparam int IX_J7  = 8;
  localparam int IX_J8  = 9;
  localparam int IX_J9  = 10;

  localparam ang_t ONE30 = 34'sd1073741824;
  localparam ang_t PI30  = 34'sd3373259426;

  // floor(n / k) = (n * ceil(2^38 / k)) >> 38, exact for n < 2^31, k <= 128
  localparam int RCP_SHIFT = 38;
  localparam logic [35:0] RCP72 = 36'(((64'd1 << RCP_SHIFT) + 64'd71) / 64'd72);
  localparam logic [35:0] RCP42 = 36'(((64'd1 << RCP_SHIFT) + 64'd41) / 64'd42);
  localparam logic [35:0] RCP20 = 36'(((64'd1 << RCP_SHIFT) + 64'd19) / 64'd20);
  localparam logic [35:0] RCP6  = 36'(((64'd1 << RCP_SHIFT) + 64'd5) / 64'd6);
  localparam logic [35:0] RCP90 = 36'(((64'd1 << RCP_SHIFT) + 64'd89) / 64'd90);
  localparam logic [35:0] RCP56 = 36'(((64'd1 << RCP_SHIFT) + 64'd55) / 64'd56);
  localparam logic [35:0] RCP30 = 36'(((64'd1 << RCP_SHIFT) + 64'd29) / 64'd30);
  localparam logic [35:0] RCP12 = 36'(((64'd1 << RCP_SHIFT) + 64'd11) / 64'd12);

  // 9/(32 pi) in Q30
  localparam logic [27:0] SCALE30 =
    28'(((64'd9 << 55) + 64'd1686629713) / 64'd3373259426);

  typedef struct packed {
    logic       cmd;
    logic [3:0] idx;
    coef_t      val;
    logic       flag;
  } ctl_t;

  // Q30 product, rounded half up
  function automatic ang_t mq(input ang_t a, input ang_t b);
    logic signed [67:0] p;
    p = a * b;
    p = p + 68'sd536870912;
    return p[63:30];
  endfunction

endpackage

// ===== rtl/angular_density_time_independent_unit.sv =====
// Angular density unit: coefficient loading and per-event density evaluation.
//
// Input channel (in_valid / in_stall): each request is either a coefficient
// write (in_command low: in_coeff_index, in_coeff_value) or an evaluation
// (in_command high: in_cos_theta_l, in_cos_theta_k, in_phi_angle).
// A write gives no result; writes to slots above ten are dropped.
// Result channel (out_valid / out_stall): out_density (Q8.24, saturated)
// and out_clamped for each evaluation, in request order.
// Throughput: one request per cycle while the pipeline is not frozen; each
// request passes through the 19-stage pipeline (square root in five
// stages, sine/cosine Horner chain in eleven, weighted sum and scaling
// in six), every stage advancing together.
// A write takes effect for all evaluations accepted after it.
// Reset clears all valid bits and zeroes the coefficient table.
// When out_stall holds a pending result, the whole pipeline freezes and
// in_stall is raised; nothing is lost or repeated.
module angular_density_time_independent_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [3:0]         in_coeff_index,
  input  logic signed [23:0] in_coeff_value,
  input  logic signed [17:0] in_cos_theta_l,
  input  logic signed [17:0] in_cos_theta_k,
  input  logic [15:0]        in_phi_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_density,
  output logic               out_clamped
);
  import adtiu_pkg::*;

  typedef struct packed {
    ang_t cl;
    ang_t ck;
    ang_t cl2;
    ang_t ck2;
  } cs_t;

  typedef struct packed {
    ang_t kl;
    ang_t skl;
    ang_t ssl;
    ang_t b0;
    ang_t b1;
    ang_t b2;
    ang_t b3;
    ang_t b7;
  } bas_t;

  logic               en;
  logic [13:1]        vld_r;
  ctl_t               ctl_nxt;
  ctl_t               ctl_r [1:13];
  logic signed [17:0] cl16_nxt, ck16_nxt, cl16_r, ck16_r;
  logic [15:0]        phi_r;
  logic [15:0]        phi2;
  ang_t               clq, ckq;
  cs_t                cs_r [2:6];
  logic [31:0]        sl_root, sk_root;
  ang_t               sl, sk;
  ang_t               sin2l_r, sin2k_r, sl2_r, sk2_r, ck2_r, cos2l_r, cl7_r, sl7_r;
  bas_t               bas_nxt;
  bas_t               bd_r [8:12];
  ang_t               cp, sp, c2p, s2p;
  ang_t               basis_r [NCOEF];
  logic               mac_vld;

  function automatic logic signed [17:0] clamp_cos(input logic signed [17:0] v);
    if (v > 18'sd65536) return 18'sd65536;
    if (v < -18'sd65536) return -18'sd65536;
    return v;
  endfunction

  function automatic ang_t to_q30(input logic signed [17:0] c);
    return ang_t'(c) <<< 14;
  endfunction

  assign en       = !(mac_vld && out_stall);
  assign in_stall = !en;

  always_comb begin
    cl16_nxt     = clamp_cos(in_cos_theta_l);
    ck16_nxt     = clamp_cos(in_cos_theta_k);
    ctl_nxt.cmd  = in_command;
    ctl_nxt.idx  = in_coeff_index;
    ctl_nxt.val  = in_coeff_value;
    ctl_nxt.flag = (cl16_nxt != in_cos_theta_l) || (ck16_nxt != in_cos_theta_k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[12:1], in_valid};
    end
  end

  assign clq  = to_q30(cl16_r);
  assign ckq  = to_q30(ck16_r);
  assign phi2 = {phi_r[14:0], 1'b0};
  assign sl   = ang_t'({2'b00, sl_root});
  assign sk   = ang_t'({2'b00, sk_root});

  always_comb begin
    bas_nxt.kl  = mq(sin2k_r, sin2l_r);
    bas_nxt.skl = mq(sin2k_r, sl7_r);
    bas_nxt.ssl = mq(sk2_r, sl2_r);
    bas_nxt.b0  = sk2_r;
    bas_nxt.b1  = ck2_r;
    bas_nxt.b2  = mq(sk2_r, cos2l_r);
    bas_nxt.b3  = mq(ck2_r, cos2l_r);
    bas_nxt.b7  = mq(sk2_r, cl7_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[1] <= ctl_nxt;
      for (int k = 2; k < 14; k++) ctl_r[k] <= ctl_r[k-1];
      cl16_r <= cl16_nxt;
      ck16_r <= ck16_nxt;
      phi_r  <= in_phi_angle;

      cs_r[2].cl  <= clq;
      cs_r[2].ck  <= ckq;
      cs_r[2].cl2 <= mq(clq, clq);
      cs_r[2].ck2 <= mq(ckq, ckq);
      for (int k = 3; k < 7; k++) cs_r[k] <= cs_r[k-1];

      sin2l_r <= mq(sl, cs_r[6].cl) <<< 1;
      sin2k_r <= mq(sk, cs_r[6].ck) <<< 1;
      sl2_r   <= ONE30 - cs_r[6].cl2;
      sk2_r   <= ONE30 - cs_r[6].ck2;
      ck2_r   <= cs_r[6].ck2;
      cos2l_r <= (cs_r[6].cl2 <<< 1) - ONE30;
      cl7_r   <= cs_r[6].cl;
      sl7_r   <= sl;

      bd_r[8] <= bas_nxt;
      for (int k = 9; k < 13; k++) bd_r[k] <= bd_r[k-1];

      basis_r[IX_J1S] <= bd_r[12].b0;
      basis_r[IX_J1C] <= bd_r[12].b1;
      basis_r[IX_J2S] <= bd_r[12].b2;
      basis_r[IX_J2C] <= bd_r[12].b3;
      basis_r[IX_J3]  <= mq(bd_r[12].ssl, c2p);
      basis_r[IX_J4]  <= mq(bd_r[12].kl, cp);
      basis_r[IX_J5]  <= mq(bd_r[12].skl, cp);
      basis_r[IX_J6]  <= bd_r[12].b7;
      basis_r[IX_J7]  <= mq(bd_r[12].skl, sp);
      basis_r[IX_J8]  <= mq(bd_r[12].kl, sp);
      basis_r[IX_J9]  <= mq(bd_r[12].ssl, s2p);
    end
  end

  adtiu_sqrt u_sqrt_l (
    .clk    (clk),
    .en     (en),
    .cos_in (cl16_r),
    .root   (sl_root)
  );

  adtiu_sqrt u_sqrt_k (
    .clk    (clk),
    .en     (en),
    .cos_in (ck16_r),
    .root   (sk_root)
  );

  adtiu_trig u_trig_1 (
    .clk (clk),
    .en  (en),
    .ang (phi_r),
    .co  (cp),
    .si  (sp)
  );

  adtiu_trig u_trig_2 (
    .clk (clk),
    .en  (en),
    .ang (phi2),
    .co  (c2p),
    .si  (s2p)
  );

  adtiu_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld_r[13]),
    .ctl_in  (ctl_r[13]),
    .basis   (basis_r),
    .out_vld (mac_vld),
    .density (out_density),
    .clamped (out_clamped)
  );

  assign out_valid = mac_vld;

endmodule

// ===== rtl/adtiu_sqrt.sv =====
// Pipelined square root of (1 - c^2) for a Q1.16 cosine, result in Q30.
module adtiu_sqrt (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] cos_in,
  output logic [31:0]        root
);

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  logic signed [35:0] sq;
  logic [32:0]        m;
  logic [63:0]        v_r [0:3];
  sq_t                st_r [1:4];

  function automatic sq_t sq_steps(input sq_t s, input logic [15:0] bits);
    logic [35:0] r;
    logic [35:0] t;
    sq_t         o;
    o = s;
    for (int i = 7; i >= 0; i--) begin
      r = {o.rem, bits[2*i +: 2]};
      t = {2'b00, o.root, 2'b01};
      if (r >= t) begin
        o.rem  = 34'(r - t);
        o.root = {o.root[30:0], 1'b1};
      end else begin
        o.rem  = r[33:0];
        o.root = {o.root[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  assign sq = cos_in * cos_in;
  assign m  = 33'(36'h1_0000_0000 - $unsigned(sq));

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]  <= {3'b000, m, 28'd0};
      st_r[1] <= sq_steps('0, v_r[0][63:48]);
      for (int k = 1; k < 4; k++) begin
        v_r[k]    <= {v_r[k-1][47:0], 16'd0};
        st_r[k+1] <= sq_steps(st_r[k], v_r[k][63:48]);
      end
    end
  end

  assign root = st_r[4].root;

endmodule

// ===== rtl/adtiu_trig.sv =====
// Pipelined cosine and sine of a 16-bit binary angle, results in Q30.
module adtiu_trig (
  input  logic              clk,
  input  logic              en,
  input  logic [15:0]       ang,
  output adtiu_pkg::ang_t   co,
  output adtiu_pkg::ang_t   si
);
  import adtiu_pkg::*;

  localparam logic [1:0] QUAD0 = 2'd0;
  localparam logic [1:0] QUAD1 = 2'd1;
  localparam logic [1:0] QUAD2 = 2'd2;
  localparam logic [1:0] QUAD3 = 2'd3;

  logic [15:0]        r;
  logic signed [14:0] t;
  logic signed [47:0] xp;
  logic signed [47:0] xs;

  logic [1:0] q_r [1:10];
  ang_t x_r  [1:9];
  ang_t x2_r [2:9];
  ang_t ps3_r, pc3_r, ms4_r, mc4_r, ps5_r, pc5_r, ms6_r, mc6_r;
  ang_t ps7_r, pc7_r, ms8_r, mc8_r, ps9_r, pc9_r, s10_r, mc10_r;
  ang_t c_nxt, co_nxt, si_nxt, co_r, si_r;

  function automatic ang_t one_minus_div(input ang_t n, input logic [35:0] m);
    logic [66:0] dp;
    dp = 67'(n[30:0]) * 67'(m);
    return ONE30 - ang_t'({5'b0, dp[66:RCP_SHIFT]});
  endfunction

  assign r  = ang + 16'h2000;
  assign t  = $signed({1'b0, r[13:0]}) - 15'sd8192;
  assign xp = t * PI30;
  assign xs = (xp + 48'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[1]  <= r[15:14];
      x_r[1]  <= xs[33:0];
      x2_r[2] <= mq(x_r[1], x_r[1]);
      x_r[2]  <= x_r[1];
      for (int k = 3; k < 10; k++) begin
        x_r[k]  <= x_r[k-1];
        x2_r[k] <= x2_r[k-1];
      end
      for (int k = 2; k < 11; k++) q_r[k] <= q_r[k-1];
      ps3_r  <= one_minus_div(x2_r[2], RCP72);
      pc3_r  <= one_minus_div(x2_r[2], RCP90);
      ms4_r  <= mq(x2_r[3], ps3_r);
      mc4_r  <= mq(x2_r[3], pc3_r);
      ps5_r  <= one_minus_div(ms4_r, RCP42);
      pc5_r  <= one_minus_div(mc4_r, RCP56);
      ms6_r  <= mq(x2_r[5], ps5_r);
      mc6_r  <= mq(x2_r[5], pc5_r);
      ps7_r  <= one_minus_div(ms6_r, RCP20);
      pc7_r  <= one_minus_div(mc6_r, RCP30);
      ms8_r  <= mq(x2_r[7], ps7_r);
      mc8_r  <= mq(x2_r[7], pc7_r);
      ps9_r  <= one_minus_div(ms8_r, RCP6);
      pc9_r  <= one_minus_div(mc8_r, RCP12);
      s10_r  <= mq(x_r[9], ps9_r);
      mc10_r <= mq(x2_r[9], pc9_r);
      co_r   <= co_nxt;
      si_r   <= si_nxt;
    end
  end

  always_comb begin
    c_nxt = ONE30 - (mc10_r >>> 1);
    unique case (q_r[10])
      QUAD0: begin
        co_nxt = c_nxt;
        si_nxt = s10_r;
      end
      QUAD1: begin
        co_nxt = -s10_r;
        si_nxt = c_nxt;
      end
      QUAD2: begin
        co_nxt = -c_nxt;
        si_nxt = -s10_r;
      end
      QUAD3: begin
        co_nxt = s10_r;
        si_nxt = -c_nxt;
      end
    endcase
  end

  assign co = co_r;
  assign si = si_r;

endmodule

// ===== rtl/adtiu_mac.sv =====
// Coefficient table, weighted sum of the basis terms, scaling and saturation.
module adtiu_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  adtiu_pkg::ctl_t     ctl_in,
  input  adtiu_pkg::ang_t     basis [adtiu_pkg::NCOEF],
  output logic                out_vld,
  output logic signed [31:0]  density,
  output logic                clamped
);
  import adtiu_pkg::*;

  coef_t              tbl_r [NCOEF];
  logic [5:0]         vld_r;
  logic [5:0]         flg_r;
  logic signed [57:0] prod_r [NCOEF];
  logic signed [63:0] part_r [3];
  logic signed [63:0] acc_r;
  logic signed [63:0] accr;
  logic signed [41:0] r24_r;
  logic signed [52:0] phi_r;
  logic [45:0]        plo_r;
  logic signed [71:0] sum;
  logic signed [71:0] ds;
  logic signed [31:0] dens_nxt, dens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int i = 0; i < NCOEF; i++) tbl_r[i] <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_in & (ctl_in.cmd == CMD_EVAL)};
      if (vld_in && ctl_in.cmd == CMD_WRITE && ctl_in.idx < 4'(NCOEF)) begin
        tbl_r[ctl_in.idx] <= ctl_in.val;
      end
    end
  end

  assign accr = (acc_r + 64'sd2097152) >>> 22;

  always_ff @(posedge clk) begin
    if (en) begin
      flg_r <= {flg_r[4:0], ctl_in.flag};
      for (int i = 0; i < NCOEF; i++) prod_r[i] <= tbl_r[i] * basis[i];
      part_r[0] <= prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3];
      part_r[1] <= prod_r[4] + prod_r[5] + prod_r[6] + prod_r[7];
      part_r[2] <= prod_r[8] + prod_r[9] + prod_r[10];
      acc_r     <= part_r[0] + part_r[1] + part_r[2];
      r24_r     <= accr[41:0];
      phi_r     <= $signed(r24_r[41:18]) * $signed({1'b0, SCALE30});
      plo_r     <= r24_r[17:0] * SCALE30;
      dens_r    <= dens_nxt;
    end
  end

  always_comb begin
    sum = (72'(phi_r) <<< 18) + $signed({26'd0, plo_r}) + 72'sd536870912;
    ds  = sum >>> 30;
    if (ds > 72'sd2147483647) begin
      dens_nxt = 32'sh7FFF_FFFF;
    end else if (ds < -72'sd2147483648) begin
      dens_nxt = 32'sh8000_0000;
    end else begin
      dens_nxt = ds[31:0];
    end
  end

  assign out_vld = vld_r[5];
  assign clamped = flg_r[5];
  assign density = dens_r;

endmodule

// ===== sim/tb.sv =====
// Testbench for the angular density unit: table-driven directed requests, then random traffic.
module tb;
  import adtiu_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = CMD_WRITE;
  logic [3:0]         in_coeff_index = '0;
  logic signed [23:0] in_coeff_value = '0;
  logic signed [17:0] in_cos_theta_l = '0;
  logic signed [17:0] in_cos_theta_k = '0;
  logic [15:0]        in_phi_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_density;
  logic               out_clamped;

  angular_density_time_independent_unit i_dut (.*);

  always #10 clk = ~clk;

  typedef struct {
    logic               cmd;
    logic [3:0]         idx;
    logic signed [23:0] val;
    logic signed [17:0] cl;
    logic signed [17:0] ck;
    logic [15:0]        phi;
  } request_t;

  typedef struct {
    logic signed [31:0] dens;
    logic               clmp;
  } density_t;

  localparam longint Q1 = 64'sd1 << 30;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint SCL = ((64'sd9 <<< 55) + 64'sd1686629713) / 64'sd3373259426;

  longint   coef_mirror [11];
  density_t density_q [$];
  int       errors = 0;
  int       mism = 0;
  bit       hold_rx = 1'b0;
  bit       tx_done = 1'b0;

  function automatic longint rnd_shr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shr(a * b, 30);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic bin_trig(input logic [15:0] ang, output longint co, output longint si);
    logic [15:0] r;
    longint t, x, x2, p, c, s;
    r = ang + 16'h2000;
    t = longint'(r[13:0]) - 64'sd8192;
    x = rnd_shr(t * PI_Q30, 15);
    x2 = qmul(x, x);
    p = Q1 - x2 / 72;
    p = Q1 - qmul(x2, p) / 42;
    p = Q1 - qmul(x2, p) / 20;
    p = Q1 - qmul(x2, p) / 6;
    s = qmul(x, p);
    p = Q1 - x2 / 90;
    p = Q1 - qmul(x2, p) / 56;
    p = Q1 - qmul(x2, p) / 30;
    p = Q1 - qmul(x2, p) / 12;
    c = Q1 - qmul(x2, p) / 2;
    case (r[15:14])
      2'd0: begin co = c; si = s; end
      2'd1: begin co = -s; si = c; end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endtask

  task automatic predict_density(input request_t rq, output density_t res);
    longint cl16, ck16, cl, ck, sl, sk, cl2, ck2, sl2, sk2, c2l, s2l, s2k;
    longint cp, sp, c2p, s2p, kl, skl, ss, acc, d;
    longint bas [11];
    res.clmp = 1'b0;
    cl16 = rq.cl;
    ck16 = rq.ck;
    if (cl16 > 65536) begin cl16 = 65536; res.clmp = 1'b1; end
    if (cl16 < -65536) begin cl16 = -65536; res.clmp = 1'b1; end
    if (ck16 > 65536) begin ck16 = 65536; res.clmp = 1'b1; end
    if (ck16 < -65536) begin ck16 = -65536; res.clmp = 1'b1; end
    cl = cl16 * 16384;
    ck = ck16 * 16384;
    sl = int_sqrt(longint'(((64'sd1 <<< 32) - cl16 * cl16) <<< 28));
    sk = int_sqrt(longint'(((64'sd1 <<< 32) - ck16 * ck16) <<< 28));
    cl2 = qmul(cl, cl);
    ck2 = qmul(ck, ck);
    sl2 = Q1 - cl2;
    sk2 = Q1 - ck2;
    c2l = 2 * cl2 - Q1;
    s2l = 2 * qmul(sl, cl);
    s2k = 2 * qmul(sk, ck);
    bin_trig(rq.phi, cp, sp);
    bin_trig(rq.phi * 16'd2, c2p, s2p);
    kl = qmul(s2k, s2l);
    skl = qmul(s2k, sl);
    ss = qmul(sk2, sl2);
    bas[IX_J1S] = sk2;
    bas[IX_J1C] = ck2;
    bas[IX_J2S] = qmul(sk2, c2l);
    bas[IX_J2C] = qmul(ck2, c2l);
    bas[IX_J3] = qmul(ss, c2p);
    bas[IX_J4] = qmul(kl, cp);
    bas[IX_J5] = qmul(skl, cp);
    bas[IX_J6] = qmul(sk2, cl);
    bas[IX_J7] = qmul(skl, sp);
    bas[IX_J8] = qmul(kl, sp);
    bas[IX_J9] = qmul(ss, s2p);
    acc = 0;
    for (int i = 0; i < NCOEF; i++) acc += coef_mirror[i] * bas[i];
    d = rnd_shr(rnd_shr(acc, 22) * SCL, 30);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    res.dens = d[31:0];
  endtask

  task automatic send_request(input request_t rq);
    density_t res;
    in_valid <= 1'b1;
    in_command <= rq.cmd;
    in_coeff_index <= rq.idx;
    in_coeff_value <= rq.val;
    in_cos_theta_l <= rq.cl;
    in_cos_theta_k <= rq.ck;
    in_phi_angle <= rq.phi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rq.cmd == CMD_EVAL) begin
      predict_density(rq, res);
      density_q.push_back(res);
    end else if (rq.idx < NCOEF) begin
      coef_mirror[rq.idx] = rq.val;
    end
  endtask

  task automatic idle_tx(input int n);
    in_valid <= 1'b0;
    in_command <= logic'($urandom);
    in_coeff_index <= 4'($urandom);
    in_coeff_value <= 24'($urandom);
    in_cos_theta_l <= 18'($urandom);
    in_cos_theta_k <= 18'($urandom);
    in_phi_angle <= 16'($urandom);
    repeat (n) @(posedge clk);
  endtask

  function automatic request_t mk(logic c, int ix, int v, int l, int k, int p);
    request_t r;
    r.cmd = c; r.idx = 4'(ix); r.val = 24'(v); r.cl = 18'(l); r.ck = 18'(k);
    r.phi = 16'(p);
    return r;
  endfunction

  function automatic logic signed [17:0] rand_cos();
    int s;
    s = $urandom_range(0, 15);
    if (s == 0) return 18'($urandom);
    if (s == 1) return ($urandom_range(0, 1) != 0) ? 18'sd65536 : -18'sd65536;
    return 18'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  request_t dir_tab [$];
  logic     dir_chk [$];
  density_t dir_exp [$];
  density_t want_q [$];
  logic     chk_q [$];

  // directed table; expected values only where obvious
  initial begin
    density_t z;
    z.dens = 0; z.clmp = 1'b0;
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 0, 0, 0)); dir_chk.push_back(1); dir_exp.push_back(z);
    z.clmp = 1'b1;
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 131071, -131072, 65535));
    dir_chk.push_back(1); dir_exp.push_back(z);
    z.clmp = 1'b0;
    dir_tab.push_back(mk(CMD_WRITE, IX_J1S, 65536, 0, 0, 0)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    for (int i = 0; i < NCOEF; i++) begin
      dir_tab.push_back(mk(CMD_WRITE, i, (i % 2) ? 8388607 : -8388608, 0, 0, 0));
      dir_chk.push_back(0); dir_exp.push_back(z);
    end
    dir_tab.push_back(mk(CMD_WRITE, 15, 12345, 0, 0, 0)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_WRITE, 11, 777, 0, 0, 0)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 65536, 65536, 0)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, -65536, 0, 16384)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 30000, -45000, 32768)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 0, 0, 49152)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 65537, -65537, 8191)); dir_chk.push_back(0);
    dir_exp.push_back(z);
    dir_tab.push_back(mk(CMD_EVAL, 0, 0, 46341, 46341, 8192)); dir_chk.push_back(0);
    dir_exp.push_back(z);
  end

  initial begin
    request_t rq;
    density_t p;
    int burst;
    for (int i = 0; i < NCOEF; i++) coef_mirror[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < dir_tab.size(); i++) begin
      rq = dir_tab[i];
      if (rq.cmd == CMD_EVAL) begin
        predict_density(rq, p);
        if (dir_chk[i]) begin
          if (p.dens !== dir_exp[i].dens || p.clmp !== dir_exp[i].clmp) begin
            errors++;
            $display("directed row %0d predictor disagrees with table", i);
          end
          p = dir_exp[i];
        end
        want_q.push_back(p);
      end
      send_request(rq);
      if ($urandom_range(0, 3) == 0) idle_tx($urandom_range(1, 3));
    end
    for (int n = 0; n < 1750; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 1750; b++, n++) begin
        if (n == 600) begin
          hold_rx = 1'b1;
        end
        rq.cmd = ($urandom_range(0, 5) == 0) ? CMD_WRITE : CMD_EVAL;
        rq.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
        case ($urandom_range(0, 5))
          0: rq.val = 24'($urandom);
          1: rq.val = ($urandom_range(0, 1) != 0) ? 24'sd8388607 : -24'sd8388608;
          default: rq.val = 24'(int'($urandom_range(0, 262144)) - 131072);
        endcase
        rq.cl = rand_cos();
        rq.ck = rand_cos();
        rq.phi = 16'($urandom);
        send_request(rq);
      end
      if ($urandom_range(0, 2) != 0) idle_tx($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    tx_done = 1'b1;
  end

  always @(posedge clk) begin
    if (hold_rx) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    wait (hold_rx);
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    density_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (density_q.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected result density=%0d", out_density);
        mism++;
      end else begin
        exp_r = density_q.pop_front();
        if (want_q.size() != 0) exp_r = want_q.pop_front();
        if (out_density !== exp_r.dens || out_clamped !== exp_r.clmp) begin
          errors++;
          if (mism < 10)
            $display("mismatch: exp density=%0d clamped=%0b, got density=%0d clamped=%0b",
                     exp_r.dens, exp_r.clmp, out_density, out_clamped);
          mism++;
        end
      end
    end
  end

  initial begin
    wait (tx_done);
    while (density_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/adtiu_pkg.sv
rtl/adtiu_sqrt.sv
rtl/adtiu_trig.sv
rtl/adtiu_mac.sv
rtl/angular_density_time_independent_unit.sv
sim/tb.sv
